FILE: design/s2x_pkg.sv
// shared constants, codes and types for the scale2x pixel upscaler
package s2x_pkg;

	// storage and field sizes
	localparam int PIXEL_BITS   = 32;
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
	localparam int COL_BITS     = 10;
	localparam int DIM_BITS     = 11;
	localparam int CFG_IDX_BITS = 2;
	localparam int OUT_RAW_BITS = 4 * PIXEL_BITS + 2 * COL_BITS;
	localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

	// register reset values
	localparam logic [DIM_BITS-1:0] RST_FRAME_WIDTH  = 11'd320;
	localparam logic [DIM_BITS-1:0] RST_FRAME_HEIGHT = 11'd224;

	// request kinds carried in tuser
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// control carried from the accept cycle to the line buffer read stage
	typedef struct packed {
		logic                 first_col;
		logic                 use_north;
		logic                 use_east;
		logic                 drain;
		logic                 prev_is_a;
		logic                 last;
		logic [COL_BITS-1:0]  col;
		logic [COL_BITS-1:0]  row;
	} s1_ctrl_t;

	// clamp a frame dimension register into 1..limit
	function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] v,
			input logic [DIM_BITS-1:0] limit);
		logic [DIM_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_BITS'(1);
		end else if (v > limit) begin
			r = limit;
		end
		return r;
	endfunction

endpackage

FILE: design/scale2x_pixel_upscaler.sv
// scale2x streaming upscaler: line buffers, read stage and output register
//
// channel   | direction | contents
// s_axis    | in        | tdata: pixel[31:0]; tuser: req_type (0 pixel, 1 drain step)
// m_axis    | out       | tdata: top_left, top_right, bottom_left, bottom_right, src_col,
//           |           |        src_row (lowest first); tlast: frame_end
// cfg       | in        | cfg_we, cfg_index (0 frame_width, 1 frame_height), cfg_data
//
// one word per clock sustained while the output is not stalled; a taken word's block passes
// the line buffer read stage, then the output register
// each line buffer takes one read and one write per cycle; east and centre come
// from the previous-row buffer, north from the current-row buffer
// reset clears counters and handshake state; line buffers start undefined
// a stalled output holds the output register and the read stage, input stalls once both are full
module scale2x_pixel_upscaler
	import s2x_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [PIXEL_BITS-1:0]   s_axis_tdata,  // pixel
	input  logic [0:0]              s_axis_tuser,  // req_type
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_BITS-1:0]     m_axis_tdata,  // top_left, top_right, bottom_left,
	                                               // bottom_right, src_col, src_row, zero pad
	output logic                    m_axis_tlast,  // frame_end
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data
);

	// configuration and frame position
	logic [DIM_BITS-1:0]   width_q, height_q;
	logic [DIM_BITS-1:0]   wdt, hgt;
	logic [COL_BITS-1:0]   col_q;
	logic [DIM_BITS-1:0]   row_q;
	logic                  draining_q;
	logic                  sel_q;
	logic [PIXEL_BITS-1:0] first_q;

	// line buffers and their registered read data
	logic [PIXEL_BITS-1:0] buf_a [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] buf_b [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] rd_a_q, rd_b_q;

	// read stage
	logic                  s1_valid_q;
	s1_ctrl_t              ctrl_s1;
	logic [PIXEL_BITS-1:0] pix_s1, first_s1;
	logic [PIXEL_BITS-1:0] east_q, west_q;

	// output register
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] tl_q, tr_q, bl_q, br_q;
	logic [COL_BITS-1:0]   ocol_q, orow_q;
	logic                  olast_q;

	logic                  accept, is_drain, take_pixel, take_drain;
	logic                  row_done, emit, s1_adv;
	logic [ADDR_BITS-1:0]  x_addr, xn_addr;
	logic [DIM_BITS-1:0]   x_ext, y_next;
	logic [PIXEL_BITS-1:0] prev_d, north_d, c_v, n_v, s_v, w_v, e_v;
	logic [PIXEL_BITS-1:0] tl_v, tr_v, bl_v, br_v;
	s1_ctrl_t              ctrl_v;

	// effective frame size
	assign wdt = sat_dim(width_q, DIM_BITS'(MAX_WIDTH));
	assign hgt = sat_dim(height_q, DIM_BITS'(MAX_HEIGHT));

	// handshake: the read stage drains into the output register when that is free
	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_drain      = (s_axis_tuser[0] == REQ_DRAIN);
	assign take_pixel    = accept && !is_drain && !draining_q;
	assign take_drain    = accept && is_drain && draining_q;

	// position decode for the word being taken
	assign x_ext    = {1'b0, col_q};
	assign row_done = (x_ext + DIM_BITS'(1)) >= wdt;
	assign y_next   = row_q + DIM_BITS'(1);
	assign x_addr   = ADDR_BITS'(col_q);
	assign xn_addr  = ADDR_BITS'(col_q + COL_BITS'(1));
	assign emit     = take_drain || (take_pixel && (row_q != '0));

	always_comb begin
		ctrl_v           = '0;
		ctrl_v.first_col = (col_q == '0);
		ctrl_v.use_east  = !row_done;
		ctrl_v.drain     = is_drain;
		ctrl_v.prev_is_a = sel_q;
		ctrl_v.col       = col_q;
		if (is_drain) begin
			ctrl_v.use_north = (row_q != '0);
			ctrl_v.last      = row_done;
			ctrl_v.row       = COL_BITS'(row_q);
		end else begin
			ctrl_v.use_north = (row_q > DIM_BITS'(1));
			ctrl_v.last      = 1'b0;
			ctrl_v.row       = COL_BITS'(row_q - DIM_BITS'(1));
		end
	end

	// line buffer a: current row when sel is low, read-first on a shared address
	always_ff @(posedge clk) begin
		if (take_pixel && !sel_q) begin
			buf_a[x_addr] <= s_axis_tdata;
		end
		if (accept) begin
			rd_a_q <= buf_a[sel_q ? xn_addr : x_addr];
		end
	end

	// line buffer b: current row when sel is high
	always_ff @(posedge clk) begin
		if (take_pixel && sel_q) begin
			buf_b[x_addr] <= s_axis_tdata;
		end
		if (accept) begin
			rd_b_q <= buf_b[sel_q ? x_addr : xn_addr];
		end
	end

	// configuration registers and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_FRAME_WIDTH;
			height_q   <= RST_FRAME_HEIGHT;
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
			sel_q      <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (take_pixel) begin
			if (row_done) begin
				col_q <= '0;
				sel_q <= !sel_q;
				if (y_next >= hgt) begin
					draining_q <= 1'b1;
				end else begin
					row_q <= y_next;
				end
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end else if (take_drain) begin
			if (row_done) begin
				col_q      <= '0;
				row_q      <= '0;
				draining_q <= 1'b0;
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	// first pixel of the row, the centre of column zero one row later
	always_ff @(posedge clk) begin
		if (take_pixel && col_q == '0) begin
			first_q <= s_axis_tdata;
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= emit;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1  <= ctrl_v;
			pix_s1   <= s_axis_tdata;
			first_s1 <= first_q;
		end
	end

	// neighbourhood and scale2x rules
	always_comb begin
		prev_d  = ctrl_s1.prev_is_a ? rd_a_q : rd_b_q;
		north_d = ctrl_s1.prev_is_a ? rd_b_q : rd_a_q;
		c_v     = ctrl_s1.first_col ? first_s1 : east_q;
		n_v     = ctrl_s1.use_north ? north_d : c_v;
		w_v     = ctrl_s1.first_col ? c_v : west_q;
		e_v     = ctrl_s1.use_east ? prev_d : c_v;
		s_v     = ctrl_s1.drain ? c_v : pix_s1;
		tl_v    = (w_v == n_v && w_v != s_v && w_v != e_v) ? w_v : c_v;
		tr_v    = (n_v == e_v && n_v != w_v && n_v != s_v) ? n_v : c_v;
		bl_v    = (w_v == s_v && w_v != n_v && w_v != e_v) ? w_v : c_v;
		br_v    = (s_v == e_v && s_v != w_v && s_v != n_v) ? s_v : c_v;
	end

	// east becomes the next centre, centre the next west
	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			east_q <= prev_d;
			west_q <= c_v;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			tl_q    <= tl_v;
			tr_q    <= tr_v;
			bl_q    <= bl_v;
			br_q    <= br_v;
			ocol_q  <= ctrl_s1.col;
			orow_q  <= ctrl_s1.row;
			olast_q <= ctrl_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {{(OUT_BITS - OUT_RAW_BITS){1'b0}}, orow_q, ocol_q,
		br_q, bl_q, tr_q, tl_q};

	// a stalled output keeps the block waiting in the read stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_axis_tready) |=> s1_valid_q)
		else $error("read stage lost a block during an output stall");

	// column position stays inside the frame during the drain
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |-> (x_ext < wdt || draining_q == 1'b0))
		else $error("column counter beyond frame width");

	// the last drain step restarts the frame
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take_drain && row_done && !cfg_we) |=> (!draining_q && row_q == '0 && col_q == '0))
		else $error("frame did not restart after the last drain step");

	// row counter stays below the frame height after each pixel taken
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(take_pixel && !cfg_we && $stable(height_q)) |=> (row_q < hgt))
		else $error("row counter beyond frame height");

endmodule

FILE: tb/sv/s2x_block_checker.sv
// scoreboard for the scale2x upscaler: predicts every 2x2 block and checks the output stream
`timescale 1ns / 100ps
module s2x_block_checker
	import s2x_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [PIXEL_BITS-1:0]   s_axis_tdata,  // pixel
	input  logic [0:0]              s_axis_tuser,  // req_type
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [OUT_BITS-1:0]     m_axis_tdata,  // top_left, top_right, bottom_left,
	                                               // bottom_right, src_col, src_row, zero pad
	input  logic                    m_axis_tlast,  // frame_end
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data,
	output int                      mismatches,
	output int                      blocks_pending
);

	typedef struct packed {
		logic [PIXEL_BITS-1:0] top_left;
		logic [PIXEL_BITS-1:0] top_right;
		logic [PIXEL_BITS-1:0] bottom_left;
		logic [PIXEL_BITS-1:0] bottom_right;
		logic [COL_BITS-1:0]   src_col;
		logic [COL_BITS-1:0]   src_row;
		logic                  frame_end;
	} out_block_t;

	// shadow copy of the block's registers and row context
	logic [DIM_BITS-1:0]   width_reg;
	logic [DIM_BITS-1:0]   height_reg;
	logic [PIXEL_BITS-1:0] row_store [2][MAX_WIDTH];
	logic                  fill_sel;    // store taking the incoming row
	int                    col_pos;
	int                    row_pos;
	logic [PIXEL_BITS-1:0] west_centre;
	logic                  in_drain;
	out_block_t            expected_blocks [$];
	int                    reports_left;

	// edge rules of the 2x expansion, neighbours already replaced at frame edges
	function automatic out_block_t scale2x_block(input logic [PIXEL_BITS-1:0] c, n, s, w, e,
			input int col, row, input logic last);
		out_block_t b;
		b.top_left     = (w == n && w != s && w != e) ? w : c;
		b.top_right    = (n == e && n != w && n != s) ? n : c;
		b.bottom_left  = (w == s && w != n && w != e) ? w : c;
		b.bottom_right = (s == e && s != w && s != n) ? s : c;
		b.src_col      = col[COL_BITS-1:0];
		b.src_row      = row[COL_BITS-1:0];
		b.frame_end    = last;
		return b;
	endfunction

	function automatic void restart_frame();
		col_pos     = 0;
		row_pos     = 0;
		west_centre = '0;
		in_drain    = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		out_block_t            got;
		out_block_t            want;
		logic [PIXEL_BITS-1:0] c;
		logic [PIXEL_BITS-1:0] n;
		logic [PIXEL_BITS-1:0] w;
		logic [PIXEL_BITS-1:0] e;
		int                    wdt;
		int                    hgt;
		logic                  row_done;
		if (!arst_n) begin
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			fill_sel   = 1'b0;
			restart_frame();
			expected_blocks.delete();
			mismatches     = 0;
			reports_left   = 10;
			blocks_pending = 0;
		end else begin
			// output words against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got.top_left     = m_axis_tdata[0 +: PIXEL_BITS];
				got.top_right    = m_axis_tdata[PIXEL_BITS +: PIXEL_BITS];
				got.bottom_left  = m_axis_tdata[2*PIXEL_BITS +: PIXEL_BITS];
				got.bottom_right = m_axis_tdata[3*PIXEL_BITS +: PIXEL_BITS];
				got.src_col      = m_axis_tdata[4*PIXEL_BITS +: COL_BITS];
				got.src_row      = m_axis_tdata[4*PIXEL_BITS+COL_BITS +: COL_BITS];
				got.frame_end    = m_axis_tlast;
				if (expected_blocks.size() == 0) begin
					mismatches++;
					if (reports_left > 0) begin
						reports_left--;
						$display("%0t: block with none predicted, col %0d row %0d",
							$time, got.src_col, got.src_row);
					end
				end else begin
					want = expected_blocks.pop_front();
					if (got !== want) begin
						mismatches++;
						if (reports_left > 0) begin
							reports_left--;
							$display("%0t: block mismatch", $time);
							$display("  expected tl %h tr %h bl %h br %h col %0d row %0d end %b",
								want.top_left, want.top_right, want.bottom_left,
								want.bottom_right, want.src_col, want.src_row, want.frame_end);
							$display("  actual   tl %h tr %h bl %h br %h col %0d row %0d end %b",
								got.top_left, got.top_right, got.bottom_left,
								got.bottom_right, got.src_col, got.src_row, got.frame_end);
						end
					end
				end
			end

			// register writes abandon the frame in progress, spare indexes do nothing
			if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					width_reg = cfg_data;
				end else begin
					height_reg = cfg_data;
				end
				restart_frame();
			end

			// input words
			if (s_axis_tvalid && s_axis_tready) begin
				wdt = (width_reg == '0) ? 1 :
					(width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
				hgt = (height_reg == '0) ? 1 :
					(height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
				row_done = (col_pos + 1 >= wdt);
				if (s_axis_tuser[0] == REQ_PIXEL) begin
					// pixels during the drain are dropped
					if (!in_drain) begin
						// the incoming pixel is the south neighbour of the row above
						if (row_pos > 0) begin
							c = row_store[!fill_sel][col_pos];
							n = (row_pos > 1) ? row_store[fill_sel][col_pos] : c;
							w = (col_pos > 0) ? west_centre : c;
							e = row_done ? c : row_store[!fill_sel][col_pos + 1];
							expected_blocks.push_back(scale2x_block(c, n, s_axis_tdata, w, e,
								col_pos, row_pos - 1, 1'b0));
							west_centre = c;
						end
						row_store[fill_sel][col_pos] = s_axis_tdata;
						if (row_done) begin
							col_pos  = 0;
							fill_sel = !fill_sel;
							if (row_pos + 1 >= hgt) begin
								in_drain = 1'b1;
							end else begin
								row_pos++;
							end
						end else begin
							col_pos++;
						end
					end
				end else if (in_drain) begin
					// last row: south mirrors the centre
					c = row_store[!fill_sel][col_pos];
					n = (row_pos > 0) ? row_store[fill_sel][col_pos] : c;
					w = (col_pos > 0) ? west_centre : c;
					e = row_done ? c : row_store[!fill_sel][col_pos + 1];
					expected_blocks.push_back(scale2x_block(c, n, c, w, e,
						col_pos, row_pos, row_done));
					west_centre = c;
					if (row_done) begin
						restart_frame();
					end else begin
						col_pos++;
					end
				end
			end
			blocks_pending = expected_blocks.size();
		end
	end

endmodule

FILE: tb/sv/tb_scale2x_pixel_upscaler.sv
// testbench top for the scale2x upscaler: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 100ps
module tb_scale2x_pixel_upscaler;
	import s2x_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 200;
	localparam int RANDOM_WORDS = 500;

	// register indexes past the defined pair
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	// output side stall patterns
	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [PIXEL_BITS-1:0]   s_axis_tdata;
	logic [0:0]              s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_BITS-1:0]     m_axis_tdata;
	logic                    m_axis_tlast;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]     cfg_data;

	int mismatches;
	int blocks_pending;
	int cycle_count = 0;
	int hold_reqs   = 0;
	int hold_seen   = 0;
	int burst_left  = 0;
	bit gaps_on     = 1'b1;
	int words_sent  = 0;

	scale2x_pixel_upscaler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	s2x_block_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.blocks_pending (blocks_pending)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: stall patterns of random length, plus long hold-offs on request
	initial begin : receiver
		int       run;
		rx_mode_e mode;
		m_axis_tready = 1'b0;
		forever begin
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			run  = $urandom_range(4, 60);
			mode = rx_mode_e'($urandom_range(0, 3));
			repeat (run) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default:   m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	// one input word, in bursts with random gaps between them
	task automatic send_word(input logic req, input logic [PIXEL_BITS-1:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				s_axis_tdata  <= $urandom;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= pix;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// stop offering words until every predicted block has left, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (blocks_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_dims(input logic [DIM_BITS-1:0] raw_w, input logic [DIM_BITS-1:0] raw_h);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, raw_w);
		write_reg(REG_FRAME_HEIGHT, raw_h);
	endtask

	// a dimension of one is sometimes written as zero
	function automatic logic [DIM_BITS-1:0] raw_dim(input int v);
		if (v == 1 && $urandom_range(0, 2) == 0) begin
			return '0;
		end
		return v[DIM_BITS-1:0];
	endfunction

	// pixels from a small palette so that neighbours often match, then drain words
	task automatic stream_frame(input int n_pix, input int n_drain, input bit noisy);
		logic [PIXEL_BITS-1:0] pal [4];
		int                    pal_n;
		int                    pause_at;
		int                    i;
		pal_n = $urandom_range(1, 4);
		for (i = 0; i < 4; i++) begin
			case ($urandom_range(0, 4))
				0:       pal[i] = '0;
				1:       pal[i] = '1;
				default: pal[i] = $urandom;
			endcase
		end
		pause_at = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(0, n_pix) : -1;
		for (i = 0; i < n_pix; i++) begin
			if (i == pause_at) begin
				wait_idle();
			end
			// stray drain inside the frame is dropped
			if (noisy && $urandom_range(0, 39) == 0) begin
				send_word(REQ_DRAIN, $urandom);
			end
			send_word(REQ_PIXEL, ($urandom_range(0, 7) == 0) ? $urandom
				: pal[$urandom_range(0, pal_n - 1)]);
			words_sent++;
		end
		for (i = 0; i < n_drain; i++) begin
			// stray pixel during the drain is dropped
			if (noisy && $urandom_range(0, 39) == 0) begin
				send_word(REQ_PIXEL, $urandom);
			end
			send_word(REQ_DRAIN, $urandom);
			words_sent++;
		end
		// drain after the frame closed is dropped
		if (noisy && n_drain != 0 && $urandom_range(0, 9) == 0) begin
			send_word(REQ_DRAIN, $urandom);
		end
	endtask

	initial begin : stimulus
		int fw;
		int fh;
		int cut;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_PIXEL;
		cfg_we        = 1'b0;
		cfg_index     = REG_FRAME_WIDTH;
		cfg_data      = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset dimensions: one full row and the start of the next
		stream_frame(int'(RST_FRAME_WIDTH) + 12, 0, 1'b0);

		// 3x2 frame with stray words around it
		set_dims(11'd3, 11'd2);
		send_word(REQ_DRAIN, '1);
		send_word(REQ_PIXEL, '0);
		send_word(REQ_PIXEL, '1);
		send_word(REQ_PIXEL, '1);
		send_word(REQ_PIXEL, '0);
		send_word(REQ_PIXEL, '0);
		send_word(REQ_PIXEL, '1);
		send_word(REQ_PIXEL, 32'h5A5A_A5A5);
		repeat (3) send_word(REQ_DRAIN, '0);
		send_word(REQ_DRAIN, '1);

		// zero dimensions count as one: single pixel frame
		set_dims('0, '0);
		send_word(REQ_PIXEL, 32'hDEAD_BEEF);
		send_word(REQ_DRAIN, '0);

		// oversized dimensions, frame dropped after a few pixels
		set_dims('1, '1);
		repeat (3) send_word(REQ_PIXEL, $urandom);

		// tallest single column, height register above range,
		// with the output held off while words keep coming
		set_dims(11'd1, 11'd2047);
		hold_reqs++;
		stream_frame(MAX_HEIGHT, 1, 1'b0);

		// random frames, mostly small
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: fw = $urandom_range(1, 8);
				7, 8:                fw = $urandom_range(9, 40);
				default:             fw = $urandom_range(41, 100);
			endcase
			fh = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			set_dims(raw_dim(fw), raw_dim(fh));
			if ($urandom_range(0, 9) == 0) begin
				hold_reqs++;
			end
			case ($urandom_range(0, 5))
				0: begin
					// frame cut short, the next register write starts over
					stream_frame($urandom_range(1, fw * fh), 0, 1'b1);
				end
				1: begin
					// spare index written mid-frame, frame carries on
					cut = $urandom_range(1, fw * fh);
					stream_frame(cut, 0, 1'b1);
					wait_idle();
					write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
						DIM_BITS'($urandom));
					stream_frame(fw * fh - cut, fw, 1'b1);
				end
				default: begin
					repeat ($urandom_range(1, 3)) stream_frame(fw * fh, fw, 1'b1);
				end
			endcase
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/s2x_pkg.sv
design/scale2x_pixel_upscaler.sv
tb/sv/s2x_block_checker.sv
tb/sv/tb_scale2x_pixel_upscaler.sv
